[sv/two_axis_histogram_bin_index_top_macros.svh]
// Assertion macros for the two-axis histogram bin index block.
// Included by the modules that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef TWO_AXIS_HISTOGRAM_BIN_INDEX_TOP_MACROS_SVH
`define TWO_AXIS_HISTOGRAM_BIN_INDEX_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define THBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define THBI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define THBI_ASSERT(lbl, prop, msg)
`define THBI_NEVER(lbl, cond, msg)
`endif
`endif

[sv/thbi_pkg.sv]
// Shared types, codes and default sizes for the two-axis histogram bin index block.
// No dependencies; imported by the top level and the merge stage.
`default_nettype none
package thbi_pkg;

  localparam int unsigned MAX_EDGES_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned LANES_DEF      = 8;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned BIN_W     = 6;
  localparam int unsigned USED_W    = 7;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_POINT  = 2'd0,
    FUNC_LOAD_E = 2'd1,
    FUNC_LOAD_R = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_E_ADJ  = 2'd0,
    CFG_R_ADJ  = 2'd1,
    CFG_E_USED = 2'd2,
    CFG_R_USED = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic rd_vld;
  } scan_ctl_t;

  typedef struct packed {
    logic             in_bin;
    logic [BIN_W-1:0] bin;
  } axis_res_t;

endpackage
`default_nettype wire

[sv/two_axis_histogram_bin_index_top.sv]
// Top level of the two-axis histogram bin index block: control, edge table lanes,
// merge stages, point counter and result register. Uses thbi_pkg, thbi_lane, thbi_merge.
//
// Load beats (func 1 and 2) and the unused func code give no result. A point
// beat scans both edge tables one row per cycle, every lane reading one entry
// of its bank per row, up to the last used row of the longer table, where the
// edge counts are clamped. A point occupies the block until its result is
// loaded into an output register, so the next beat is taken while it waits
// to be drained.
`default_nettype none
`include "two_axis_histogram_bin_index_top_macros.svh"
module two_axis_histogram_bin_index_top #(
  parameter int unsigned MAX_EDGES  = thbi_pkg::MAX_EDGES_DEF,
  parameter int unsigned VALUE_BITS = thbi_pkg::VALUE_BITS_DEF,
  parameter int unsigned LANES      = thbi_pkg::LANES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_wr_en_i,
  input  wire logic [thbi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [thbi_pkg::USED_W-1:0]      cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [thbi_pkg::FUNC_W-1:0]      func_i,
  input  wire logic [thbi_pkg::SLOT_W-1:0]      edge_slot_i,
  input  wire logic [thbi_pkg::FIELD_W-1:0]     edge_value_i,
  input  wire logic [thbi_pkg::FIELD_W-1:0]     energy_i,
  input  wire logic [thbi_pkg::FIELD_W-1:0]     radius_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  inside_res_o,
  output logic      [thbi_pkg::BIN_W-1:0]       energy_bin_o,
  output logic      [thbi_pkg::BIN_W-1:0]       radius_bin_o,
  output logic      [thbi_pkg::CNT_W-1:0]       binned_total_o
);
  import thbi_pkg::*;

  localparam int unsigned VW        = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int unsigned LANE_BITS = $clog2(LANES);
  localparam int unsigned ROWS      = (MAX_EDGES + LANES - 1) / LANES;
  localparam int unsigned ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned KW        = ROW_BITS + LANE_BITS;
  localparam int unsigned CW        = $clog2(MAX_EDGES + 1);

  function automatic logic [CW-1:0] clamp_used(input logic [USED_W-1:0] u);
    logic [CW-1:0] r;
    if (32'(u) < 32'd2) begin
      r = CW'(2);
    end else if (32'(u) > MAX_EDGES) begin
      r = CW'(MAX_EDGES);
    end else begin
      r = CW'(u);
    end
    return r;
  endfunction

  function automatic logic [ROW_BITS-1:0] last_row_of(input logic [CW-1:0] n);
    logic [KW+CW-1:0] ext;
    ext = {{KW{1'b0}}, n - CW'(1)};
    return ext[LANE_BITS +: ROW_BITS];
  endfunction

  state_e              state_q, state_d;
  logic                e_adj_q, r_adj_q;
  logic [USED_W-1:0]   e_used_q, r_used_q;
  logic [CW-1:0]       e_n, r_n;
  logic [ROW_BITS-1:0] e_last_row, r_last_row;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [ROW_BITS-1:0] scan_last_q;
  logic [ROW_BITS-1:0] rd_row_q;
  logic                rd_vld_q;
  logic [VW-1:0]       e_val_q, r_val_q;
  logic                in_acc;
  logic                pt_acc;
  logic                slot_ok;
  logic                e_we, r_we;
  logic [KW+SLOT_W-1:0] slot_ext;
  logic [LANE_BITS-1:0] wr_lane;
  logic [ROW_BITS-1:0]  wr_row;
  logic                out_load;
  logic                out_valid_q, out_valid_d;
  logic                inside_q;
  logic [BIN_W-1:0]    ebin_q, rbin_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                both_in;
  scan_ctl_t           scan_ctl;
  axis_res_t           e_res, r_res;
  logic [LANES-1:0]    e_hit, r_hit;
  logic [VW-1:0]       e_data [LANES];
  logic [VW-1:0]       r_data [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_adj_q  <= 1'b1;
      r_adj_q  <= 1'b1;
      e_used_q <= USED_W'(2);
      r_used_q <= USED_W'(2);
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_E_ADJ:  e_adj_q  <= cfg_wdata_i[0];
        CFG_R_ADJ:  r_adj_q  <= cfg_wdata_i[0];
        CFG_E_USED: e_used_q <= cfg_wdata_i;
        CFG_R_USED: r_used_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign e_n        = clamp_used(e_used_q);
  assign r_n        = clamp_used(r_used_q);
  assign e_last_row = last_row_of(e_n);
  assign r_last_row = last_row_of(r_n);

  assign in_acc   = in_valid_i && !in_stall_o;
  assign pt_acc   = in_acc && (func_e'(func_i) == FUNC_POINT);
  assign slot_ok  = 32'(edge_slot_i) < MAX_EDGES;
  assign e_we     = in_acc && (func_e'(func_i) == FUNC_LOAD_E) && slot_ok;
  assign r_we     = in_acc && (func_e'(func_i) == FUNC_LOAD_R) && slot_ok;
  assign slot_ext = {{KW{1'b0}}, edge_slot_i};
  assign wr_lane  = slot_ext[LANE_BITS-1:0];
  assign wr_row   = slot_ext[LANE_BITS +: ROW_BITS];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pt_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (row_q == scan_last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o      = 1'b1;
    out_load        = 1'b0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.rd_vld = rd_vld_q;
    row_d           = row_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (pt_acc) begin
          scan_ctl.clear = 1'b1;
          row_d          = '0;
        end
      end
      ST_SCAN: begin
        row_d = row_q + ROW_BITS'(1);
      end
      ST_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    rd_row_q <= row_q;
    if (pt_acc) begin
      e_val_q     <= energy_i[VW-1:0];
      r_val_q     <= radius_i[VW-1:0];
      scan_last_q <= (e_last_row > r_last_row) ? e_last_row : r_last_row;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    thbi_lane #(
      .VW       (VW),
      .ROWS     (ROWS),
      .ROW_BITS (ROW_BITS),
      .LANE_BITS(LANE_BITS),
      .LANE_IDX (l),
      .CW       (CW)
    ) u_e_lane (
      .clk_i    (clk_i),
      .wr_en_i  (e_we && (wr_lane == LANE_BITS'(l))),
      .wr_addr_i(wr_row),
      .wr_data_i(edge_value_i[VW-1:0]),
      .rd_addr_i(row_q),
      .rd_row_i (rd_row_q),
      .value_i  (e_val_q),
      .used_i   (e_n),
      .hit_o    (e_hit[l]),
      .data_o   (e_data[l])
    );

    thbi_lane #(
      .VW       (VW),
      .ROWS     (ROWS),
      .ROW_BITS (ROW_BITS),
      .LANE_BITS(LANE_BITS),
      .LANE_IDX (l),
      .CW       (CW)
    ) u_r_lane (
      .clk_i    (clk_i),
      .wr_en_i  (r_we && (wr_lane == LANE_BITS'(l))),
      .wr_addr_i(wr_row),
      .wr_data_i(edge_value_i[VW-1:0]),
      .rd_addr_i(row_q),
      .rd_row_i (rd_row_q),
      .value_i  (r_val_q),
      .used_i   (r_n),
      .hit_o    (r_hit[l]),
      .data_o   (r_data[l])
    );
  end

  thbi_merge #(
    .VW       (VW),
    .LANES    (LANES),
    .LANE_BITS(LANE_BITS),
    .ROW_BITS (ROW_BITS),
    .CW       (CW)
  ) u_e_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .rd_row_i  (rd_row_q),
    .hit_i     (e_hit),
    .data_i    (e_data),
    .value_i   (e_val_q),
    .used_i    (e_n),
    .adjacent_i(e_adj_q),
    .res_o     (e_res)
  );

  thbi_merge #(
    .VW       (VW),
    .LANES    (LANES),
    .LANE_BITS(LANE_BITS),
    .ROW_BITS (ROW_BITS),
    .CW       (CW)
  ) u_r_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .rd_row_i  (rd_row_q),
    .hit_i     (r_hit),
    .data_i    (r_data),
    .value_i   (r_val_q),
    .used_i    (r_n),
    .adjacent_i(r_adj_q),
    .res_o     (r_res)
  );

  assign both_in = e_res.in_bin && r_res.in_bin;

  always_comb begin
    cnt_d = cnt_q;
    if (out_load && both_in && (cnt_q != '1)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      inside_q <= both_in;
      ebin_q   <= both_in ? e_res.bin : '0;
      rbin_q   <= both_in ? r_res.bin : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign inside_res_o   = inside_q;
  assign energy_bin_o   = ebin_q;
  assign radius_bin_o   = rbin_q;
  assign binned_total_o = cnt_q;

  `THBI_ASSERT(a_point_starts_scan, pt_acc |=> (state_q == ST_SCAN), "point beat did not start a scan")
  `THBI_ASSERT(a_row_in_bounds, (state_q == ST_SCAN) |-> (row_q <= scan_last_q), "scan row overran")
  `THBI_ASSERT(a_count_on_inside, (cnt_q != $past(cnt_q)) |-> (out_valid_q && inside_q), "count moved without an inside result")
  `THBI_NEVER(a_inside_nonzero, out_valid_o && inside_res_o && (binned_total_o == '0), "inside result with zero total")

endmodule
`default_nettype wire

[sv/thbi_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for every edge table bank.
`default_nettype none
module thbi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                         wr_data_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

[sv/thbi_lane.sv]
// One lane of one axis: a bank of the edge table and the edge-versus-value compare.
// Depends on thbi_ram.
`default_nettype none
module thbi_lane #(
  parameter int unsigned VW        = 32,
  parameter int unsigned ROWS      = 8,
  parameter int unsigned ROW_BITS  = 3,
  parameter int unsigned LANE_BITS = 3,
  parameter int unsigned LANE_IDX  = 0,
  parameter int unsigned CW        = 7
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [ROW_BITS-1:0] wr_addr_i,
  input  wire logic [VW-1:0]       wr_data_i,
  input  wire logic [ROW_BITS-1:0] rd_addr_i,
  input  wire logic [ROW_BITS-1:0] rd_row_i,
  input  wire logic [VW-1:0]       value_i,
  input  wire logic [CW-1:0]       used_i,
  output logic                     hit_o,
  output logic      [VW-1:0]       data_o
);

  localparam int unsigned KW = ROW_BITS + LANE_BITS;

  logic [VW-1:0] rd_data;
  logic [KW-1:0] slot_idx;

  thbi_ram #(
    .WIDTH(VW),
    .DEPTH(ROWS)
  ) u_bank (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en_i),
    .wr_addr_i(wr_addr_i),
    .wr_data_i(wr_data_i),
    .rd_addr_i(rd_addr_i),
    .rd_data_o(rd_data)
  );

  assign slot_idx = {rd_row_i, LANE_BITS'(LANE_IDX)};
  assign hit_o    = (rd_data >= value_i) &&
                    ({{CW{1'b0}}, slot_idx} < {{KW{1'b0}}, used_i});
  assign data_o   = rd_data;

endmodule
`default_nettype wire

[sv/thbi_merge.sv]
// Merge stage of one axis: picks the first hit across lanes and rows, keeps the
// first and last used edges, and forms the in-range flag and bin. Uses thbi_pkg.
`default_nettype none
module thbi_merge #(
  parameter int unsigned VW        = 32,
  parameter int unsigned LANES     = 8,
  parameter int unsigned LANE_BITS = 3,
  parameter int unsigned ROW_BITS  = 3,
  parameter int unsigned CW        = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire thbi_pkg::scan_ctl_t   ctl_i,
  input  wire logic [ROW_BITS-1:0]   rd_row_i,
  input  wire logic [LANES-1:0]      hit_i,
  input  wire logic [VW-1:0]         data_i [LANES],
  input  wire logic [VW-1:0]         value_i,
  input  wire logic [CW-1:0]         used_i,
  input  wire logic                  adjacent_i,
  output thbi_pkg::axis_res_t        res_o
);
  import thbi_pkg::*;

  localparam int unsigned KW = ROW_BITS + LANE_BITS;

  logic                 found_q, found_d;
  logic [KW-1:0]        idx_q;
  logic [VW-1:0]        first_q;
  logic [VW-1:0]        last_q;
  logic                 any_hit;
  logic [LANE_BITS-1:0] hit_lane;
  logic [CW-1:0]        used_m1;
  logic [KW+CW-1:0]     used_m1_ext;
  logic [ROW_BITS-1:0]  last_row;
  logic [LANE_BITS-1:0] last_lane;
  logic                 axis_in;
  logic [KW-1:0]        bin_full;
  logic [KW+BIN_W-1:0]  bin_ext;

  always_comb begin
    any_hit  = 1'b0;
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hit_i[l]) begin
        any_hit  = 1'b1;
        hit_lane = LANE_BITS'(l);
      end
    end
  end

  assign used_m1     = used_i - CW'(1);
  assign used_m1_ext = {{KW{1'b0}}, used_m1};
  assign last_row    = used_m1_ext[LANE_BITS +: ROW_BITS];
  assign last_lane   = used_m1_ext[LANE_BITS-1:0];

  always_comb begin
    found_d = found_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (ctl_i.rd_vld && any_hit) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_vld && !found_q && any_hit) begin
      idx_q <= {rd_row_i, hit_lane};
    end
    if (ctl_i.rd_vld && (rd_row_i == '0)) begin
      first_q <= data_i[0];
    end
    if (ctl_i.rd_vld && (rd_row_i == last_row)) begin
      last_q <= data_i[last_lane];
    end
  end

  assign axis_in  = found_q && (value_i > first_q) && (value_i < last_q) &&
                    (idx_q != '0) && (adjacent_i || idx_q[0]);
  assign bin_full = adjacent_i ? (idx_q - KW'(1)) : (idx_q >> 1);
  assign bin_ext  = {{BIN_W{1'b0}}, bin_full};

  assign res_o.in_bin = axis_in;
  assign res_o.bin    = axis_in ? bin_ext[BIN_W-1:0] : '0;

endmodule
`default_nettype wire
